### hw/rtl/i2c_slave_frame_mailbox_defines.svh
// assertion macros shared by the mailbox rtl
`ifndef I2C_SLAVE_FRAME_MAILBOX_DEFINES_SVH
`define I2C_SLAVE_FRAME_MAILBOX_DEFINES_SVH

// checked property, idle while reset is high
`define ISFM_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("mailbox check failed");

// checked property, also during reset
`define ISFM_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("mailbox check failed");

`endif

### hw/rtl/isfm_pkg.sv
// types, codes and sizes of the i2c slave frame mailbox
package isfm_pkg;

  localparam int FRAME_BYTES = 8;
  localparam int IDX_W = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
  localparam int CNT_W = $clog2(FRAME_BYTES + 1);
  localparam int ADDR_W = 7;

  localparam logic [ADDR_W-1:0] OWN_ADDRESS_RESET = 7'd1;

  localparam logic [3:0] CMD_BUSERR    = 4'd0;
  localparam logic [3:0] CMD_ADDRWRITE = 4'd1;
  localparam logic [3:0] CMD_RXBYTE    = 4'd2;
  localparam logic [3:0] CMD_STOP      = 4'd3;
  localparam logic [3:0] CMD_ADDRREAD  = 4'd4;
  localparam logic [3:0] CMD_TXNEXT    = 4'd5;
  localparam logic [3:0] CMD_TXEND     = 4'd6;
  localparam logic [3:0] CMD_OTHER     = 4'd7;
  localparam logic [3:0] CMD_TAKEREQ   = 4'd8;
  localparam logic [3:0] CMD_PUTRESP   = 4'd9;

  localparam logic [1:0] REQ_NONE     = 2'd0;
  localparam logic [1:0] REQ_READY    = 2'd1;
  localparam logic [1:0] REQ_REJECTED = 2'd2;

  typedef struct packed {
    logic [3:0] cmd;
    logic [7:0] data_byte;
    logic [3:0] byte_index;
    logic       last;
  } item_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic [1:0] request_state;
    logic [7:0] frame_byte;
    logic       last_of_run;
    logic       response_accepted;
    logic       request_available;
  } result_t;

  typedef struct packed {
    logic exec;
    logic step;
  } dp_cmd_t;

  typedef struct packed {
    logic more;
  } dp_stat_t;

endpackage

### hw/rtl/isfm_ctrl.sv
// handshake controller of the mailbox: accepts a word, shows its results
`include "i2c_slave_frame_mailbox_defines.svh"

module isfm_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_ready,
  output logic               result_valid,
  input  logic               result_ready,
  input  isfm_pkg::dp_stat_t stat,
  output isfm_pkg::dp_cmd_t  ctl
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_SHOW = 1'b1;

  logic state;
  logic state_next;

  always_comb begin
    item_ready   = (state == S_IDLE) && !rst;
    result_valid = (state == S_SHOW);
    ctl.exec     = item_valid && (state == S_IDLE) && !rst;
    ctl.step     = (state == S_SHOW) && result_ready && stat.more;
    state_next   = state;
    case (state)
      S_IDLE: begin
        if (item_valid) state_next = S_SHOW;
      end
      S_SHOW: begin
        if (result_ready && !stat.more) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  `ISFM_ASSERT(a_exec_shows, clk, rst, ctl.exec |=> result_valid)
  `ISFM_ASSERT(a_step_shows, clk, rst, ctl.step |=> result_valid)
  `ISFM_ASSERT(a_done_frees, clk, rst,
    (result_valid && result_ready && !stat.more) |=> item_ready)

endmodule

### hw/rtl/isfm_datapath.sv
// mailbox datapath: frame stores, flags, counters and result register
`include "i2c_slave_frame_mailbox_defines.svh"

module isfm_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [isfm_pkg::ADDR_W-1:0]   cfg_wdata,
  input  isfm_pkg::item_t               item,
  input  isfm_pkg::dp_cmd_t             ctl,
  output isfm_pkg::dp_stat_t            stat,
  output isfm_pkg::result_t             result
);

  localparam logic [isfm_pkg::IDX_W-1:0] K_LAST =
    isfm_pkg::IDX_W'(isfm_pkg::FRAME_BYTES - 1);

  logic [isfm_pkg::ADDR_W-1:0] own_address;

  logic [7:0] rbuf [isfm_pkg::FRAME_BYTES];
  logic [7:0] pend [isfm_pkg::FRAME_BYTES];
  logic [7:0] rej  [isfm_pkg::FRAME_BYTES];
  logic [7:0] stg  [isfm_pkg::FRAME_BYTES];
  logic [7:0] snd  [isfm_pkg::FRAME_BYTES];

  logic [isfm_pkg::CNT_W-1:0] rcnt, rcnt_next;
  logic [isfm_pkg::CNT_W-1:0] scnt, scnt_next;
  logic ovf, ovf_next;
  logic rw, rw_next;
  logic busy, busy_next;
  logic rejw, rejw_next;
  logic rr, rr_next;
  logic svalid, svalid_next;

  logic                       run;
  logic                       src_rej;
  logic [isfm_pkg::IDX_W-1:0] k;
  logic [isfm_pkg::IDX_W-1:0] k_inc;

  logic       rx_write, to_pend, to_rej, load_snd, stg_write;
  logic       take, take_rej, acc, av;
  logic [7:0] tx;
  logic [1:0] st;

  always_comb begin
    rcnt_next   = rcnt;
    scnt_next   = scnt;
    ovf_next    = ovf;
    rw_next     = rw;
    busy_next   = busy;
    rejw_next   = rejw;
    rr_next     = rr;
    svalid_next = svalid;
    rx_write    = 1'b0;
    to_pend     = 1'b0;
    to_rej      = 1'b0;
    load_snd    = 1'b0;
    stg_write   = 1'b0;
    take        = 1'b0;
    take_rej    = 1'b0;
    acc         = 1'b0;
    tx          = 8'd0;
    st          = isfm_pkg::REQ_NONE;
    case (item.cmd)
      isfm_pkg::CMD_BUSERR, isfm_pkg::CMD_OTHER: begin
        rcnt_next   = '0;
        ovf_next    = 1'b0;
        svalid_next = 1'b0;
        scnt_next   = '0;
      end
      isfm_pkg::CMD_ADDRWRITE: begin
        rcnt_next = '0;
        ovf_next  = 1'b0;
      end
      isfm_pkg::CMD_RXBYTE: begin
        if (32'(rcnt) < isfm_pkg::FRAME_BYTES) begin
          rx_write  = 1'b1;
          rcnt_next = rcnt + 1'b1;
        end else begin
          ovf_next = 1'b1;
        end
      end
      isfm_pkg::CMD_STOP: begin
        if (32'(rcnt) == isfm_pkg::FRAME_BYTES && !ovf) begin
          if (rw || busy) begin
            if (!rejw) begin
              to_rej    = 1'b1;
              rejw_next = 1'b1;
            end
          end else begin
            to_pend = 1'b1;
            rw_next = 1'b1;
            rr_next = 1'b0;
          end
        end
        rcnt_next = '0;
        ovf_next  = 1'b0;
      end
      isfm_pkg::CMD_ADDRREAD: begin
        load_snd    = 1'b1;
        svalid_next = rr;
        scnt_next   = isfm_pkg::CNT_W'(1);
        tx          = rr ? stg[0] : 8'd0;
      end
      isfm_pkg::CMD_TXNEXT: begin
        if (32'(scnt) < isfm_pkg::FRAME_BYTES) begin
          tx        = snd[scnt[isfm_pkg::IDX_W-1:0]];
          scnt_next = scnt + 1'b1;
        end
      end
      isfm_pkg::CMD_TXEND: begin
        if (svalid && 32'(scnt) >= isfm_pkg::FRAME_BYTES) rr_next = 1'b0;
        svalid_next = 1'b0;
        scnt_next   = '0;
      end
      isfm_pkg::CMD_TAKEREQ: begin
        if (rw && !busy) begin
          take      = 1'b1;
          rw_next   = 1'b0;
          busy_next = 1'b1;
          st        = isfm_pkg::REQ_READY;
        end else if (rejw && !busy && !rr) begin
          take      = 1'b1;
          take_rej  = 1'b1;
          rejw_next = 1'b0;
          busy_next = 1'b1;
          st        = isfm_pkg::REQ_REJECTED;
        end
      end
      isfm_pkg::CMD_PUTRESP: begin
        if (busy && !rr) begin
          stg_write = (32'(item.byte_index) < isfm_pkg::FRAME_BYTES);
          if (item.last) begin
            rr_next   = 1'b1;
            busy_next = 1'b0;
            acc       = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
    av = rw_next || (rejw_next && !busy_next && !rr_next);
  end

  assign k_inc     = k + 1'b1;
  assign stat.more = run && (k != K_LAST);

  always_ff @(posedge clk) begin
    if (rst) begin
      own_address <= isfm_pkg::OWN_ADDRESS_RESET;
      rcnt        <= '0;
      scnt        <= '0;
      ovf         <= 1'b0;
      rw          <= 1'b0;
      busy        <= 1'b0;
      rejw        <= 1'b0;
      rr          <= 1'b0;
      svalid      <= 1'b0;
      run         <= 1'b0;
    end else begin
      if (cfg_we) own_address <= cfg_wdata;
      if (ctl.exec) begin
        rcnt   <= rcnt_next;
        scnt   <= scnt_next;
        ovf    <= ovf_next;
        rw     <= rw_next;
        busy   <= busy_next;
        rejw   <= rejw_next;
        rr     <= rr_next;
        svalid <= svalid_next;
        run    <= take;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.exec) begin
      if (rx_write) rbuf[rcnt[isfm_pkg::IDX_W-1:0]] <= item.data_byte;
      if (stg_write) stg[item.byte_index[isfm_pkg::IDX_W-1:0]] <= item.data_byte;
      for (int i = 0; i < isfm_pkg::FRAME_BYTES; i++) begin
        if (to_pend) pend[i] <= rbuf[i];
        if (to_rej) rej[i] <= rbuf[i];
        if (load_snd) snd[i] <= rr ? stg[i] : 8'd0;
      end
      src_rej                  <= take_rej;
      k                        <= '0;
      result.tx_byte           <= tx;
      result.request_state     <= st;
      result.frame_byte        <= take ? (take_rej ? rej[0] : pend[0]) : 8'd0;
      result.last_of_run       <= !take || (isfm_pkg::FRAME_BYTES == 1);
      result.response_accepted <= acc;
      result.request_available <= av;
    end else if (ctl.step) begin
      k                  <= k_inc;
      result.frame_byte  <= src_rej ? rej[k_inc] : pend[k_inc];
      result.last_of_run <= (k_inc == K_LAST);
    end
  end

  `ISFM_ASSERT(a_wait_not_busy, clk, rst, !(rw && busy))
  `ISFM_ASSERT(a_rcnt_bound, clk, rst, 32'(rcnt) <= isfm_pkg::FRAME_BYTES)
  `ISFM_ASSERT(a_addr_hold, clk, rst, !cfg_we |=> $stable(own_address))

endmodule

### hw/rtl/i2c_slave_frame_mailbox.sv
// top level of the i2c slave frame mailbox
// one word is handled at a time; its first result is valid in the cycle after acceptance
// a successful take request gives FRAME_BYTES results, one each cycle the result is taken
// a new word is accepted the cycle after the last result is taken
// synchronous reset clears flags and byte counts, not k, src_rej, result or frame stores
module i2c_slave_frame_mailbox (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [isfm_pkg::ADDR_W-1:0] cfg_wdata,
  input  logic                        item_valid,
  output logic                        item_ready,
  input  isfm_pkg::item_t             item,
  output logic                        result_valid,
  input  logic                        result_ready,
  output isfm_pkg::result_t           result
);

  isfm_pkg::dp_cmd_t  ctl;
  isfm_pkg::dp_stat_t stat;

  isfm_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .stat         (stat),
    .ctl          (ctl)
  );

  isfm_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .item      (item),
    .ctl       (ctl),
    .stat      (stat),
    .result    (result)
  );

endmodule

### dv/i2c_slave_frame_mailbox_test.sv
// testbench of the i2c slave frame mailbox: directed and random words against a model
`timescale 1ns / 100ps

module i2c_slave_frame_mailbox_test;

  localparam int LIMIT_CYCLES = 2000000;
  localparam int RANDOM_WORDS = 110;
  localparam logic [3:0] CMD_UNUSED_TOP = 4'd15;

  logic                        clk;
  logic                        rst;
  logic                        cfg_we;
  logic [isfm_pkg::ADDR_W-1:0] cfg_wdata;
  logic                        item_valid;
  logic                        item_ready;
  isfm_pkg::item_t             item;
  logic                        result_valid;
  logic                        result_ready;
  isfm_pkg::result_t           result;

  i2c_slave_frame_mailbox u_top (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .item_valid  (item_valid),
    .item_ready  (item_ready),
    .item        (item),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result      (result)
  );

  // mailbox model state
  logic [7:0] rx_buf     [isfm_pkg::FRAME_BYTES];
  logic [7:0] req_copy   [isfm_pkg::FRAME_BYTES];
  logic [7:0] rej_copy   [isfm_pkg::FRAME_BYTES];
  logic [7:0] resp_stage [isfm_pkg::FRAME_BYTES];
  logic [7:0] tx_copy    [isfm_pkg::FRAME_BYTES];
  int rx_cnt;
  int tx_cnt;
  bit rx_over;
  bit req_pend;
  bit req_active;
  bit rej_pend;
  bit resp_ready;
  bit tx_live;

  isfm_pkg::item_t   words_to_send[$];
  isfm_pkg::result_t results_due[$];
  int error_count;
  int cycle_count;
  int gap_left;
  int stall_left;
  int phase_words;
  bit gaps_on;

  always #6 clk = ~clk;

  function automatic bit host_can_take();
    return req_pend || (rej_pend && !req_active && !resp_ready);
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!gaps_on || r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic mailbox_apply(input isfm_pkg::item_t w);
    isfm_pkg::result_t r;
    logic [1:0]        outcome;
    logic [7:0]        taken [isfm_pkg::FRAME_BYTES];
    r = '0;
    r.last_of_run = 1'b1;
    outcome = isfm_pkg::REQ_NONE;
    case (w.cmd)
      isfm_pkg::CMD_BUSERR, isfm_pkg::CMD_OTHER: begin
        rx_cnt = 0;
        rx_over = 0;
        tx_live = 0;
        tx_cnt = 0;
      end
      isfm_pkg::CMD_ADDRWRITE: begin
        rx_cnt = 0;
        rx_over = 0;
      end
      isfm_pkg::CMD_RXBYTE: begin
        if (rx_cnt < isfm_pkg::FRAME_BYTES) begin
          rx_buf[rx_cnt] = w.data_byte;
          rx_cnt++;
        end else begin
          rx_over = 1;
        end
      end
      isfm_pkg::CMD_STOP: begin
        if (rx_cnt == isfm_pkg::FRAME_BYTES && !rx_over) begin
          if (req_pend || req_active) begin
            if (!rej_pend) begin
              rej_copy = rx_buf;
              rej_pend = 1;
            end
          end else begin
            req_copy = rx_buf;
            req_pend = 1;
            resp_ready = 0;
          end
        end
        rx_cnt = 0;
        rx_over = 0;
      end
      isfm_pkg::CMD_ADDRREAD: begin
        tx_live = resp_ready;
        foreach (tx_copy[k]) tx_copy[k] = tx_live ? resp_stage[k] : 8'h00;
        tx_cnt = 1;
        r.tx_byte = tx_copy[0];
      end
      isfm_pkg::CMD_TXNEXT: begin
        if (tx_cnt < isfm_pkg::FRAME_BYTES) begin
          r.tx_byte = tx_copy[tx_cnt];
          tx_cnt++;
        end
      end
      isfm_pkg::CMD_TXEND: begin
        if (tx_live && tx_cnt >= isfm_pkg::FRAME_BYTES) resp_ready = 0;
        tx_live = 0;
        tx_cnt = 0;
      end
      isfm_pkg::CMD_TAKEREQ: begin
        if (req_pend && !req_active) begin
          outcome = isfm_pkg::REQ_READY;
          req_pend = 0;
          req_active = 1;
          taken = req_copy;
        end else if (rej_pend && !req_active && !resp_ready) begin
          outcome = isfm_pkg::REQ_REJECTED;
          rej_pend = 0;
          req_active = 1;
          taken = rej_copy;
        end
      end
      isfm_pkg::CMD_PUTRESP: begin
        if (req_active && !resp_ready) begin
          if (w.byte_index < isfm_pkg::FRAME_BYTES) resp_stage[w.byte_index] = w.data_byte;
          if (w.last) begin
            resp_ready = 1;
            req_active = 0;
            r.response_accepted = 1'b1;
          end
        end
      end
      default: ;
    endcase
    r.request_available = host_can_take();
    if (outcome != isfm_pkg::REQ_NONE) begin
      for (int k = 0; k < isfm_pkg::FRAME_BYTES; k++) begin
        r.request_state = outcome;
        r.frame_byte = taken[k];
        r.last_of_run = (k == isfm_pkg::FRAME_BYTES - 1);
        results_due.push_back(r);
      end
    end else begin
      results_due.push_back(r);
    end
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      error_count++;
    end
  endtask

  task automatic check_result(input isfm_pkg::result_t want);
    check_field("tx_byte", want.tx_byte, result.tx_byte);
    check_field("request_state", 8'(want.request_state), 8'(result.request_state));
    check_field("frame_byte", want.frame_byte, result.frame_byte);
    check_field("last_of_run", 8'(want.last_of_run), 8'(result.last_of_run));
    check_field("response_accepted", 8'(want.response_accepted),
                8'(result.response_accepted));
    check_field("request_available", 8'(want.request_available),
                8'(result.request_available));
  endtask

  task automatic post_word(input logic [3:0] cmd, input logic [7:0] data,
                           input logic [3:0] idx, input logic fin);
    isfm_pkg::item_t w;
    w.cmd = cmd;
    w.data_byte = data;
    w.byte_index = idx;
    w.last = fin;
    words_to_send.push_back(w);
    phase_words++;
  endtask

  task automatic post_cmd(input logic [3:0] cmd);
    post_word(cmd, 8'($urandom), 4'($urandom), 1'($urandom));
  endtask

  task automatic send_frame();
    int n;
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) n = isfm_pkg::FRAME_BYTES;
    else if (r < 87) n = $urandom_range(1, isfm_pkg::FRAME_BYTES - 1);
    else n = $urandom_range(isfm_pkg::FRAME_BYTES + 1, isfm_pkg::FRAME_BYTES + 3);
    post_cmd(isfm_pkg::CMD_ADDRWRITE);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 39) == 0) begin
        post_cmd($urandom_range(0, 1) ? isfm_pkg::CMD_BUSERR : isfm_pkg::CMD_OTHER);
      end
      post_cmd(isfm_pkg::CMD_RXBYTE);
    end
    post_cmd(isfm_pkg::CMD_STOP);
  endtask

  task automatic send_response();
    int n;
    n = ($urandom_range(0, 4) != 0) ? isfm_pkg::FRAME_BYTES
                                    : $urandom_range(0, isfm_pkg::FRAME_BYTES - 1);
    for (int k = 0; k < n; k++) post_word(isfm_pkg::CMD_PUTRESP, 8'($urandom), 4'(k), 1'b0);
    post_word(isfm_pkg::CMD_PUTRESP, 8'($urandom), 4'($urandom_range(0, 15)), 1'b1);
  endtask

  task automatic send_read();
    int n;
    if ($urandom_range(0, 3) != 0) begin
      n = $urandom_range(isfm_pkg::FRAME_BYTES - 1, isfm_pkg::FRAME_BYTES + 1);
    end else begin
      n = $urandom_range(0, isfm_pkg::FRAME_BYTES - 2);
    end
    post_cmd(isfm_pkg::CMD_ADDRREAD);
    repeat (n) post_cmd(isfm_pkg::CMD_TXNEXT);
    post_cmd(($urandom_range(0, 9) != 0) ? isfm_pkg::CMD_TXEND : isfm_pkg::CMD_BUSERR);
  endtask

  task automatic directed_words();
    logic [7:0] d;
    // first read defines the copy being sent, so later txnext never sees stale bytes
    post_cmd(isfm_pkg::CMD_ADDRREAD);
    post_cmd(isfm_pkg::CMD_TXNEXT);
    post_word(CMD_UNUSED_TOP, 8'hFF, 4'hF, 1'b1);
    post_cmd(isfm_pkg::CMD_TAKEREQ);
    post_word(isfm_pkg::CMD_PUTRESP, 8'hA5, 4'h0, 1'b1);
    post_cmd(isfm_pkg::CMD_ADDRWRITE);
    post_word(isfm_pkg::CMD_RXBYTE, 8'h00, 4'h0, 1'b0);
    post_word(isfm_pkg::CMD_RXBYTE, 8'hFF, 4'hF, 1'b1);
    repeat (isfm_pkg::FRAME_BYTES - 2) post_cmd(isfm_pkg::CMD_RXBYTE);
    post_cmd(isfm_pkg::CMD_STOP);
    post_cmd(isfm_pkg::CMD_TAKEREQ);
    // whole response written once, then committed on a word outside the frame
    for (int k = 0; k < isfm_pkg::FRAME_BYTES; k++) begin
      d = (k == 0) ? 8'hFF : 8'($urandom);
      post_word(isfm_pkg::CMD_PUTRESP, d, 4'(k), 1'b0);
    end
    post_word(isfm_pkg::CMD_PUTRESP, 8'h00, 4'hF, 1'b1);
    post_cmd(isfm_pkg::CMD_ADDRREAD);
    repeat (isfm_pkg::FRAME_BYTES) post_cmd(isfm_pkg::CMD_TXNEXT);
    post_cmd(isfm_pkg::CMD_TXEND);
    post_cmd(isfm_pkg::CMD_BUSERR);
    post_cmd(isfm_pkg::CMD_OTHER);
  endtask

  task automatic random_phase(input int target);
    int r;
    phase_words = 0;
    while (phase_words < target) begin
      r = $urandom_range(0, 99);
      if (r < 30) send_frame();
      else if (r < 45) post_cmd(isfm_pkg::CMD_TAKEREQ);
      else if (r < 65) send_response();
      else if (r < 85) send_read();
      else begin
        repeat ($urandom_range(1, 3)) begin
          post_word(4'($urandom_range(0, 15)), 8'($urandom), 4'($urandom), 1'($urandom));
        end
      end
    end
  endtask

  task automatic wait_drained();
    while (words_to_send.size() != 0 || item_valid || results_due.size() != 0) @(negedge clk);
  endtask

  task automatic write_address(input logic [isfm_pkg::ADDR_W-1:0] a);
    wait_drained();
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= a;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // word driver
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      item <= '0;
      gap_left <= 0;
    end else begin
      if (item_valid && item_ready) mailbox_apply(item);
      if (!item_valid || item_ready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          item_valid <= 1'b0;
        end else if (words_to_send.size() != 0) begin
          item <= words_to_send.pop_front();
          item_valid <= 1'b1;
          gap_left <= pick_gap();
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
      stall_left <= 0;
    end else begin
      if (result_valid && result_ready) begin
        if (results_due.size() == 0) begin
          $error("result word with nothing expected: %p", result);
          error_count++;
        end else begin
          check_result(results_due.pop_front());
        end
      end
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        result_ready <= 1'b0;
      end else begin
        result_ready <= 1'b1;
        stall_left <= ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    gaps_on = 1'b1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    write_address({isfm_pkg::ADDR_W{1'b1}});
    directed_words();
    write_address(isfm_pkg::OWN_ADDRESS_RESET);
    random_phase(RANDOM_WORDS);
    gaps_on = 1'b0;
    write_address(7'($urandom_range(2, 126)));
    random_phase(RANDOM_WORDS);
    gaps_on = 1'b1;
    write_address({isfm_pkg::ADDR_W{1'b1}});
    random_phase(RANDOM_WORDS);
    write_address(7'($urandom_range(1, 127)));
    random_phase(RANDOM_WORDS);
    wait_drained();
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### i2c_slave_frame_mailbox.f
+incdir+hw/rtl
hw/rtl/isfm_pkg.sv
hw/rtl/isfm_ctrl.sv
hw/rtl/isfm_datapath.sv
hw/rtl/i2c_slave_frame_mailbox.sv
dv/i2c_slave_frame_mailbox_test.sv
